// ----- hdl/gcs_pkg.sv -----
package gcs_pkg;

    localparam int NUM_LEGS = 4;
    localparam int TICK_W   = 32;
    localparam int NSEG_W   = 5;     // clamped segment count, 1..16
    localparam int IPC_W    = 10;    // ticks per segment
    localparam int PER_W    = 14;    // cycle length in ticks, at most 16 * 1023
    localparam int LEG_T_W  = 18;    // byte * ticks per segment
    localparam int BYTE_W   = 8;
    localparam int ROW_W    = 4;
    localparam int SEG_W    = 4;
    localparam int MASK_W   = 4;
    localparam int Q_W      = 17;    // Q0.16 fraction, 0 .. 1.0
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int ROWS_MAX = 16;

    localparam logic [Q_W-1:0] Q_ONE = Q_W'(65536);

    localparam logic [NSEG_W-1:0] RST_NUM_SEGMENTS = NSEG_W'(16);
    localparam logic [IPC_W-1:0]  RST_ITERS        = IPC_W'(1);
    localparam logic [CFG_W-1:0]  RST_OFFSETS      = '0;
    localparam logic [CFG_W-1:0]  RST_DURATIONS    = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_SEGMENTS = 2'd0,
        REG_ITERS        = 2'd1,
        REG_OFFSETS      = 2'd2,
        REG_DURATIONS    = 2'd3
    } cfg_idx_t;

    typedef logic [Q_W-1:0] q_t;

    typedef struct packed {
        logic [NSEG_W-1:0] num_segments;
        logic [IPC_W-1:0]  iters_per_segment;
        logic [CFG_W-1:0]  leg_offsets;
        logic [CFG_W-1:0]  leg_durations;
    } cfg_t;

    // one tick, worked out by the front, expanded into rows by the back
    typedef struct packed {
        logic [NSEG_W-1:0] n;
        logic [SEG_W-1:0]  cur_seg;
        q_t [NUM_LEGS-1:0] stance;
        q_t [NUM_LEGS-1:0] swing;
    } desc_t;

    function automatic logic [BYTE_W-1:0] leg_byte(input logic [CFG_W-1:0] bytes_v,
                                                   input int leg);
        return bytes_v[BYTE_W*leg +: BYTE_W];
    endfunction

endpackage

// ----- hdl/gcs_front.sv -----
module gcs_front #(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gcs_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [gcs_pkg::TICK_W-1:0]  tick_count,
    output logic                        desc_valid,
    input  logic                        desc_stall,
    output gcs_pkg::desc_t              desc
);

    localparam int NL       = gcs_pkg::NUM_LEGS;
    localparam int NW       = gcs_pkg::NSEG_W;
    localparam int IW       = gcs_pkg::IPC_W;
    localparam int PW       = gcs_pkg::PER_W;
    localparam int LW       = gcs_pkg::LEG_T_W;
    localparam int QW       = gcs_pkg::Q_W;
    localparam int DW       = gcs_pkg::TICK_W;
    localparam int SGW      = gcs_pkg::SEG_W;
    localparam int SW       = LW + 4;           // signed tick arithmetic
    localparam int RW       = LW + 1;           // lane remainder
    localparam int SDW      = IW + SGW - 1;     // ipc << 3
    localparam int LANES    = 2 * NL;
    localparam int MOD_STEPS = DW / 2;
    localparam int CNT_W    = $clog2(QW);
    localparam int ROW_CAP  = (MAX_SEGMENTS < gcs_pkg::ROWS_MAX) ? MAX_SEGMENTS
                                                                  : gcs_pkg::ROWS_MAX;

    typedef enum logic [2:0] {
        S_IDLE, S_MOD, S_PREP, S_SET1, S_SET2, S_DIV, S_PUSH
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [DW-1:0]     dvd_reg;
    logic [PW-1:0]     rem_reg;
    logic [NW-1:0]     n_reg;
    logic [IW-1:0]     ipc_reg;
    logic [PW-1:0]     per_reg;

    logic [LW-1:0]     off_t_reg [NL];
    logic [LW-1:0]     dur_t_reg [NL];
    logic signed [SW-1:0] st_prog_reg  [NL];
    logic signed [SW-1:0] sw_start_reg [NL];
    logic signed [SW-1:0] sw_win_reg   [NL];

    logic [RW-1:0]     lane_rem_reg [LANES];
    logic [LW-1:0]     lane_div_reg [LANES];
    logic [QW-1:0]     lane_q_reg   [LANES];
    logic [LANES-1:0]  lane_ok_reg;

    logic [PW-1:0]     seg_rem_reg;
    logic [SDW-1:0]    seg_div_reg;
    logic [SGW-1:0]    seg_q_reg;

    logic [NW-1:0]     n_eff;
    logic [IW-1:0]     ipc_eff;
    logic [PW:0]       mod_m1, mod_m2;
    logic [PW-1:0]     mod_r1, mod_r2;
    logic signed [SW-1:0] t_s, per_s;
    logic signed [SW-1:0] off_s [NL];
    logic signed [SW-1:0] dur_s [NL];
    logic signed [SW-1:0] st_prog_c  [NL];
    logic signed [SW-1:0] sw_start_c [NL];
    logic signed [SW-1:0] sw_win_c   [NL];
    logic signed [SW-1:0] sw_prog_c  [NL];
    logic [LANES-1:0]  lane_ge;
    logic [LW-1:0]     lane_d [LANES];
    logic              seg_ge;

    assign in_stall   = (state_reg != S_IDLE);
    assign desc_valid = (state_reg == S_PUSH);

    // register values as the datapath takes them
    always_comb
    begin
        if (cfg.num_segments == '0)
            n_eff = NW'(1);
        else if (cfg.num_segments > NW'(ROW_CAP))
            n_eff = NW'(ROW_CAP);
        else
            n_eff = cfg.num_segments;
        ipc_eff = (cfg.iters_per_segment == '0) ? IW'(1) : cfg.iters_per_segment;
    end

    // tick mod period, two restoring steps a cycle
    always_comb
    begin
        mod_m1 = {rem_reg, dvd_reg[DW-1]};
        mod_r1 = (mod_m1 >= {1'b0, per_reg}) ? PW'(mod_m1 - {1'b0, per_reg})
                                             : mod_m1[PW-1:0];
        mod_m2 = {mod_r1, dvd_reg[DW-2]};
        mod_r2 = (mod_m2 >= {1'b0, per_reg}) ? PW'(mod_m2 - {1'b0, per_reg})
                                             : mod_m2[PW-1:0];
    end

    // window setup, per leg
    always_comb
    begin
        t_s   = $signed(SW'(rem_reg));
        per_s = $signed(SW'(per_reg));
        for (int leg = 0; leg < NL; leg++)
        begin
            off_s[leg] = $signed(SW'(off_t_reg[leg]));
            dur_s[leg] = $signed(SW'(dur_t_reg[leg]));
            st_prog_c[leg] = t_s - off_s[leg];
            if (st_prog_c[leg] < 0)
                st_prog_c[leg] = st_prog_c[leg] + per_s;
            sw_start_c[leg] = off_s[leg] + dur_s[leg];
            if (sw_start_c[leg] > per_s)
                sw_start_c[leg] = sw_start_c[leg] - per_s;
            sw_win_c[leg] = per_s - dur_s[leg];
            sw_prog_c[leg] = t_s - sw_start_reg[leg];
            if (sw_prog_c[leg] < 0)
                sw_prog_c[leg] = sw_prog_c[leg] + per_s;
        end
    end

    // fraction lanes, one quotient bit per cycle each
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lane_ge[i] = (lane_rem_reg[i] >= {1'b0, lane_div_reg[i]});
            lane_d[i]  = lane_ge[i] ? LW'(lane_rem_reg[i] - {1'b0, lane_div_reg[i]})
                                    : lane_rem_reg[i][LW-1:0];
        end
        seg_ge = (seg_rem_reg >= PW'(seg_div_reg));
    end

    always_comb
    begin
        desc.n       = n_reg;
        desc.cur_seg = seg_q_reg;
        for (int leg = 0; leg < NL; leg++)
        begin
            desc.stance[leg] = lane_ok_reg[leg] ? lane_q_reg[leg] : '0;
            desc.swing[leg]  = lane_ok_reg[NL+leg] ? lane_q_reg[NL+leg] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_MOD;
                        cnt_reg   <= CNT_W'(MOD_STEPS - 1);
                    end
                end
                S_MOD:
                begin
                    if (cnt_reg == '0)
                        state_reg <= S_PREP;
                    else
                        cnt_reg <= cnt_reg - CNT_W'(1);
                end
                S_PREP:
                begin
                    state_reg <= S_SET1;
                end
                S_SET1:
                begin
                    state_reg <= S_SET2;
                end
                S_SET2:
                begin
                    state_reg <= S_DIV;
                    cnt_reg   <= CNT_W'(QW - 1);
                end
                S_DIV:
                begin
                    if (cnt_reg == '0)
                        state_reg <= S_PUSH;
                    else
                        cnt_reg <= cnt_reg - CNT_W'(1);
                end
                S_PUSH:
                begin
                    if (!desc_stall)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            dvd_reg <= tick_count;
            rem_reg <= '0;
            n_reg   <= n_eff;
            ipc_reg <= ipc_eff;
            per_reg <= PW'(PW'(n_eff) * PW'(ipc_eff));
        end
        if (state_reg == S_MOD)
        begin
            dvd_reg <= {dvd_reg[DW-3:0], 2'b00};
            rem_reg <= mod_r2;
        end
        if (state_reg == S_PREP)
        begin
            for (int leg = 0; leg < NL; leg++)
            begin
                off_t_reg[leg] <= LW'(gcs_pkg::leg_byte(cfg.leg_offsets, leg)) * LW'(ipc_reg);
                dur_t_reg[leg] <= LW'(gcs_pkg::leg_byte(cfg.leg_durations, leg)) * LW'(ipc_reg);
            end
            seg_rem_reg <= rem_reg;
            seg_div_reg <= {ipc_reg, {(SGW-1){1'b0}}};
            seg_q_reg   <= '0;
        end
        if (state_reg == S_SET1)
        begin
            for (int leg = 0; leg < NL; leg++)
            begin
                st_prog_reg[leg]  <= st_prog_c[leg];
                sw_start_reg[leg] <= sw_start_c[leg];
                sw_win_reg[leg]   <= sw_win_c[leg];
            end
        end
        if (state_reg == S_SET2)
        begin
            for (int leg = 0; leg < NL; leg++)
            begin
                lane_rem_reg[leg]    <= st_prog_reg[leg][RW-1:0];
                lane_div_reg[leg]    <= dur_t_reg[leg];
                lane_ok_reg[leg]     <= (dur_s[leg] > 0) && (st_prog_reg[leg] >= 0)
                                        && (st_prog_reg[leg] <= dur_s[leg]);
                lane_rem_reg[NL+leg] <= sw_prog_c[leg][RW-1:0];
                lane_div_reg[NL+leg] <= sw_win_reg[leg][LW-1:0];
                lane_ok_reg[NL+leg]  <= (sw_win_reg[leg] > 0) && (sw_prog_c[leg] >= 0)
                                        && (sw_prog_c[leg] <= sw_win_reg[leg]);
            end
            for (int i = 0; i < LANES; i++)
                lane_q_reg[i] <= '0;
        end
        if (state_reg == S_DIV)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                lane_rem_reg[i] <= {lane_d[i], 1'b0};
                lane_q_reg[i]   <= {lane_q_reg[i][QW-2:0], lane_ge[i]};
            end
            // current segment = t / ipc, four restoring steps at the start of the DIV state
            if (cnt_reg >= CNT_W'(QW - SGW))
            begin
                if (seg_ge)
                    seg_rem_reg <= seg_rem_reg - PW'(seg_div_reg);
                seg_div_reg <= seg_div_reg >> 1;
                seg_q_reg   <= {seg_q_reg[SGW-2:0], seg_ge};
            end
        end
    end

    a_seg_in_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid |-> ({1'b0, desc.cur_seg} < desc.n))
        else $error("current segment not below segment count");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid |-> (desc.stance[0] <= gcs_pkg::Q_ONE && desc.stance[1] <= gcs_pkg::Q_ONE
                     && desc.stance[2] <= gcs_pkg::Q_ONE && desc.stance[3] <= gcs_pkg::Q_ONE
                     && desc.swing[0] <= gcs_pkg::Q_ONE && desc.swing[1] <= gcs_pkg::Q_ONE
                     && desc.swing[2] <= gcs_pkg::Q_ONE && desc.swing[3] <= gcs_pkg::Q_ONE))
        else $error("sub-phase fraction above one");

endmodule

// ----- hdl/gcs_queue.sv -----
module gcs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  gcs_pkg::desc_t  in_data,
    output logic            out_valid,
    input  logic            out_pop,
    output gcs_pkg::desc_t  out_data
);

    localparam int DEPTH = gcs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gcs_pkg::desc_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               push;
    logic               pop;

    assign in_stall  = (cnt_reg == CNT_W'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_pop && out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_data;
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue fill above depth");

endmodule

// ----- hdl/gcs_back.sv -----
module gcs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gcs_pkg::cfg_t                 cfg,
    input  logic                          head_valid,
    input  gcs_pkg::desc_t                head,
    output logic                          head_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gcs_pkg::ROW_W-1:0]     row_index,
    output logic [gcs_pkg::MASK_W-1:0]    contact_mask,
    output gcs_pkg::q_t                   stance_q [gcs_pkg::NUM_LEGS],
    output gcs_pkg::q_t                   swing_q  [gcs_pkg::NUM_LEGS],
    output logic                          last_row
);

    localparam int NL  = gcs_pkg::NUM_LEGS;
    localparam int NW  = gcs_pkg::NSEG_W;
    localparam int RWW = gcs_pkg::ROW_W;
    localparam int BW  = gcs_pkg::BYTE_W;
    localparam int PSW = BW + 2;   // signed segment difference

    logic               out_valid_reg;
    logic [RWW-1:0]     row_reg;
    logic [RWW-1:0]     row_index_reg;
    logic [NL-1:0]      mask_reg;
    gcs_pkg::q_t        stance_reg [NL];
    gcs_pkg::q_t        swing_reg  [NL];
    logic               last_reg;

    logic               load;
    logic               last_c;
    logic [NW-1:0]      seg_sum;
    logic [NW-1:0]      seg_c;
    logic signed [PSW-1:0] p_c [NL];
    logic [NL-1:0]      mask_c;

    assign load     = head_valid && (!out_valid_reg || !out_stall);
    assign last_c   = ({1'b0, row_reg} == head.n - NW'(1));
    assign head_pop = load && last_c;

    // segment of this row and the stance test per leg
    always_comb
    begin
        seg_sum = {1'b0, row_reg} + {1'b0, head.cur_seg};
        seg_c   = (seg_sum >= head.n) ? seg_sum - head.n : seg_sum;
        for (int leg = 0; leg < NL; leg++)
        begin
            p_c[leg] = $signed(PSW'(seg_c))
                     - $signed(PSW'(gcs_pkg::leg_byte(cfg.leg_offsets, leg)));
            if (p_c[leg] < 0)
                p_c[leg] = p_c[leg] + $signed(PSW'(head.n));
            mask_c[leg] = (p_c[leg] < $signed(PSW'(gcs_pkg::leg_byte(cfg.leg_durations, leg))));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                row_reg       <= last_c ? '0 : row_reg + RWW'(1);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_index_reg <= row_reg;
            mask_reg      <= mask_c;
            last_reg      <= last_c;
            for (int leg = 0; leg < NL; leg++)
            begin
                stance_reg[leg] <= head.stance[leg];
                swing_reg[leg]  <= head.swing[leg];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_index    = row_index_reg;
    assign contact_mask = mask_reg;
    assign last_row     = last_reg;
    assign stance_q     = stance_reg;
    assign swing_q      = swing_reg;

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ({1'b0, row_reg} < head.n))
        else $error("row counter past segment count");

endmodule

// ----- hdl/gait_contact_scheduler_core.sv -----
// Four-leg gait contact scheduler.
// Input channel (in_valid / in_stall / tick_count): one word is a controller
// tick count. Output channel (out_valid / out_stall / row fields): each tick
// gives n words, one per horizon row, row 0 first; last_row marks row n-1.
// Every row carries the contact mask of its segment plus the stance and swing
// sub-phase of the current tick as Q0.16 fractions.
// Config port (cfg_wr_en / cfg_index / cfg_data): write only while idle.
// Timing: the front holds in_stall high while it works on a tick: tick mod
// period at two bits a cycle, three setup states, the divide state in which
// eight fraction lanes each resolve their quotient bits, and a hand-off
// state that gives the word to the queue; so a new tick is taken only once
// the last one is handed off. The rows of a tick follow one per cycle while
// out_stall is low. A two-entry queue sits between front and back, so the
// next tick is worked on while rows of the previous one drain.
// Reset clears both sides and the queue and loads the register defaults
// (16 segments, 1 tick per segment, zero offsets and durations).
// While out_stall is high the output word holds; the queue fills, then the
// front waits in its hand-off state and in_stall stays high.
module gait_contact_scheduler_core #(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [gcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gcs_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [gcs_pkg::TICK_W-1:0]        tick_count,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [gcs_pkg::ROW_W-1:0]         row_index,
    output logic [gcs_pkg::MASK_W-1:0]        contact_mask,
    output logic [gcs_pkg::Q_W-1:0]           stance_phase_0,
    output logic [gcs_pkg::Q_W-1:0]           stance_phase_1,
    output logic [gcs_pkg::Q_W-1:0]           stance_phase_2,
    output logic [gcs_pkg::Q_W-1:0]           stance_phase_3,
    output logic [gcs_pkg::Q_W-1:0]           swing_phase_0,
    output logic [gcs_pkg::Q_W-1:0]           swing_phase_1,
    output logic [gcs_pkg::Q_W-1:0]           swing_phase_2,
    output logic [gcs_pkg::Q_W-1:0]           swing_phase_3,
    output logic                              last_row
);

    gcs_pkg::cfg_t      cfg_reg;

    // front -> queue
    logic               desc_valid;
    logic               desc_stall;
    gcs_pkg::desc_t     desc;

    // queue -> back
    logic               head_valid;
    logic               head_pop;
    gcs_pkg::desc_t     head;

    gcs_pkg::q_t        stance_q [gcs_pkg::NUM_LEGS];
    gcs_pkg::q_t        swing_q  [gcs_pkg::NUM_LEGS];

    // configuration registers; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_segments      <= gcs_pkg::RST_NUM_SEGMENTS;
            cfg_reg.iters_per_segment <= gcs_pkg::RST_ITERS;
            cfg_reg.leg_offsets       <= gcs_pkg::RST_OFFSETS;
            cfg_reg.leg_durations     <= gcs_pkg::RST_DURATIONS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                gcs_pkg::REG_NUM_SEGMENTS:
                    cfg_reg.num_segments <= cfg_data[gcs_pkg::NSEG_W-1:0];
                gcs_pkg::REG_ITERS:
                    cfg_reg.iters_per_segment <= cfg_data[gcs_pkg::IPC_W-1:0];
                gcs_pkg::REG_OFFSETS:
                    cfg_reg.leg_offsets <= cfg_data;
                gcs_pkg::REG_DURATIONS:
                    cfg_reg.leg_durations <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // front: per-tick sub-phases and current segment
    gcs_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .tick_count (tick_count),
        .desc_valid (desc_valid),
        .desc_stall (desc_stall),
        .desc       (desc)
    );

    // decouples tick processing from row output
    gcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (desc_valid),
        .in_stall   (desc_stall),
        .in_data    (desc),
        .out_valid  (head_valid),
        .out_pop    (head_pop),
        .out_data   (head)
    );

    // back: one row word per cycle while out_stall is low, contact mask per row
    gcs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head         (head),
        .head_pop     (head_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .row_index    (row_index),
        .contact_mask (contact_mask),
        .stance_q     (stance_q),
        .swing_q      (swing_q),
        .last_row     (last_row)
    );

    assign stance_phase_0 = stance_q[0];
    assign stance_phase_1 = stance_q[1];
    assign stance_phase_2 = stance_q[2];
    assign stance_phase_3 = stance_q[3];
    assign swing_phase_0  = swing_q[0];
    assign swing_phase_1  = swing_q[1];
    assign swing_phase_2  = swing_q[2];
    assign swing_phase_3  = swing_q[3];

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Gait contact scheduler bench: tick words in, one row word per horizon
// segment out. Rows are predicted per accepted tick and checked in order.
module tb_top;

    import gcs_pkg::*;

    localparam int MAX_SEGMENTS   = 16;
    localparam int SEG_CAP        = (MAX_SEGMENTS < ROWS_MAX) ? MAX_SEGMENTS : ROWS_MAX;
    localparam int LATENCY        = 48;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off, fills the descriptor queue
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
    localparam int REPORT_MAX     = 10;
    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 32;

    // directed ticks, grouped by register setup; group 0 runs on reset defaults
    localparam int DIR_GROUPS = 5;
    localparam int DIR_WORDS  = 23;
    localparam logic [31:0] DIR_TICKS [DIR_WORDS] = '{
        32'd0, 32'd7, 32'd15, 32'd16, 32'hFFFF_FFFF,
        32'd0, 32'd5, 32'd6, 32'd11, 32'd12, 32'hFFFF_FFFF,
        32'd0, 32'd1, 32'h1234_5678, 32'hFFFF_FFFF,
        32'd0, 32'd4091, 32'd16367, 32'd16368, 32'h8000_0000, 32'hFFFF_FFFF,
        32'd0, 32'd31
    };
    localparam int DIR_GROUP_END [DIR_GROUPS] = '{5, 11, 15, 21, 23};
    // group 1: trot-like, one leg in stance for the whole cycle (zero swing window)
    // group 2: segment and tick counts of 0, offsets past the cycle, stance longer than it
    // group 3: counts above the cap, slowest segments, full and empty stance
    // group 4: segment count just over the cap, offsets equal to the count
    localparam logic [31:0] DIR_NSEG [DIR_GROUPS] = '{
        32'd16, 32'd4, 32'd0, 32'hFFFF_FFFF, 32'd17
    };
    localparam logic [31:0] DIR_IPC [DIR_GROUPS] = '{
        32'd1, 32'd3, 32'd0, 32'h0000_FFFF, 32'd1
    };
    localparam logic [31:0] DIR_OFFS [DIR_GROUPS] = '{
        32'h0, 32'h0302_0100, 32'hFFFF_FFFF, 32'h0F08_0400, 32'h1000_0F01
    };
    localparam logic [31:0] DIR_DURS [DIR_GROUPS] = '{
        32'h0, 32'h0402_0102, 32'hFF01_0080, 32'h1008_0100, 32'h0010_020F
    };

    // one row word as seen on the output port
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [MASK_W-1:0] mask;
        q_t [NUM_LEGS-1:0] stance;
        q_t [NUM_LEGS-1:0] swing;
        logic              last;
    } gait_row_t;

    // Row predictor plus the queue of rows still owed by the block.
    class contact_schedule_board;
        gait_row_t         pending_rows[$];
        int unsigned       errors;
        logic [NSEG_W-1:0] seg_count;
        logic [IPC_W-1:0]  ticks_per_seg;
        logic [CFG_W-1:0]  offsets;
        logic [CFG_W-1:0]  durations;

        function new();
            errors        = 0;
            seg_count     = RST_NUM_SEGMENTS;
            ticks_per_seg = RST_ITERS;
            offsets       = RST_OFFSETS;
            durations     = RST_DURATIONS;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_NUM_SEGMENTS: seg_count     = value[NSEG_W-1:0];
                REG_ITERS:        ticks_per_seg = value[IPC_W-1:0];
                REG_OFFSETS:      offsets       = value;
                REG_DURATIONS:    durations     = value;
                default: ;
            endcase
        endfunction

        function int eff_segments();
            int n;
            n = seg_count;
            if (n < 1) n = 1;
            if (n > SEG_CAP) n = SEG_CAP;
            return n;
        endfunction

        function int eff_ticks();
            return (ticks_per_seg == 0) ? 1 : int'(ticks_per_seg);
        endfunction

        function int cycle_ticks();
            return eff_segments() * eff_ticks();
        endfunction

        // Q0.16 share of a window; outside 0..window or an empty window gives 0
        function longint q16(longint progress, longint window);
            if (window <= 0 || progress < 0 || progress > window)
                return 0;
            return (progress * 65536) / window;
        endfunction

        function void note_tick(logic [TICK_W-1:0] tick);
            longint            n, ipc, period, t, off_t, dur_t, prog;
            longint            sw_start, sw_win, sw_prog;
            longint unsigned   tk;
            int                cur_seg, seg, p;
            q_t                stance_q [NUM_LEGS];
            q_t                swing_q [NUM_LEGS];
            gait_row_t         row;
            n       = eff_segments();
            ipc     = eff_ticks();
            period  = n * ipc;
            tk      = tick;
            t       = tk % period;
            cur_seg = int'((tk / ipc) % n);
            for (int leg = 0; leg < NUM_LEGS; leg++) begin
                off_t = longint'(offsets[8*leg +: 8]) * ipc;
                dur_t = longint'(durations[8*leg +: 8]) * ipc;
                prog  = t - off_t;
                if (prog < 0) prog += period;
                stance_q[leg] = q_t'(q16(prog, dur_t));
                // swing starts where stance ends, folded back once into the cycle
                sw_start = off_t + dur_t;
                if (sw_start > period) sw_start -= period;
                sw_win  = period - dur_t;
                sw_prog = t - sw_start;
                if (sw_prog < 0) sw_prog += period;
                swing_q[leg] = q_t'(q16(sw_prog, sw_win));
            end
            for (int r = 0; r < n; r++) begin
                seg      = int'((r + cur_seg) % n);
                row.row  = ROW_W'(r);
                row.mask = '0;
                for (int leg = 0; leg < NUM_LEGS; leg++) begin
                    // large offsets may leave p negative; that still counts as stance
                    p = seg - int'(offsets[8*leg +: 8]);
                    if (p < 0) p += int'(n);
                    if (p < int'(durations[8*leg +: 8])) row.mask[leg] = 1'b1;
                    row.stance[leg] = stance_q[leg];
                    row.swing[leg]  = swing_q[leg];
                end
                row.last = (r == n - 1);
                pending_rows.push_back(row);
            end
        endfunction

        function void check_field(string what, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("row mismatch on %s: expected %0d, got %0d", what, want, got);
            end
        endfunction

        function void check_row(gait_row_t got);
            gait_row_t want;
            if (pending_rows.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected row word, row_index %0d", got.row);
                return;
            end
            want = pending_rows.pop_front();
            check_field("row_index", want.row, got.row);
            check_field("contact_mask", want.mask, got.mask);
            for (int leg = 0; leg < NUM_LEGS; leg++) begin
                check_field($sformatf("stance_phase_%0d", leg), want.stance[leg],
                            got.stance[leg]);
                check_field($sformatf("swing_phase_%0d", leg), want.swing[leg],
                            got.swing[leg]);
            end
            check_field("last_row", want.last, got.last);
        endfunction

        function int outstanding();
            return pending_rows.size();
        endfunction

        function void close();
            if (pending_rows.size() != 0) begin
                errors++;
                $display("%0d row words never arrived", pending_rows.size());
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [TICK_W-1:0]    tick_count;
    logic                 out_valid;
    logic                 out_stall;
    logic [ROW_W-1:0]     row_index;
    logic [MASK_W-1:0]    contact_mask;
    logic [Q_W-1:0]       stance_phase_0, stance_phase_1, stance_phase_2, stance_phase_3;
    logic [Q_W-1:0]       swing_phase_0, swing_phase_1, swing_phase_2, swing_phase_3;
    logic                 last_row;

    contact_schedule_board board;
    int                    gap_pct      = 0;    // sender idle odds, percent per word
    int                    stall_pct    = 0;    // receiver stall odds, percent per cycle
    bit                    hold_request = 1'b0; // asks the receiver for one long hold-off
    bit                    valid_up     = 1'b0; // mirrors in_valid as driven by the sender
    int                    idle_cycles  = 0;

    gait_contact_scheduler_core #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .tick_count(tick_count),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .row_index(row_index),
        .contact_mask(contact_mask),
        .stance_phase_0(stance_phase_0),
        .stance_phase_1(stance_phase_1),
        .stance_phase_2(stance_phase_2),
        .stance_phase_3(stance_phase_3),
        .swing_phase_0(swing_phase_0),
        .swing_phase_1(swing_phase_1),
        .swing_phase_2(swing_phase_2),
        .swing_phase_3(swing_phase_3),
        .last_row(last_row)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly zero; short bursts of 1..3, now and then a long one.
    function automatic int idle_len(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // Next tick: most often the controller's own count going up by one, plus
    // jumps, wraps of the 32-bit counter and whole multiples of the cycle.
    function automatic logic [TICK_W-1:0] next_tick(logic [TICK_W-1:0] prev);
        int unsigned period;
        period = board.cycle_ticks();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return prev + 1;
            4:          return prev + $urandom_range(1, period);
            5, 6:       return $urandom();
            7:          return $urandom_range(0, 4 * period);
            8:          return 32'hFFFF_FFFF - $urandom_range(0, 2 * period);
            default:    return period * $urandom_range(0, 100) - $urandom_range(0, 1);
        endcase
    endfunction

    // Sampling at the edge sees pre-edge values on both sides, so the
    // prediction and the check never depend on process order in a step.
    always @(posedge clk)
    begin : monitor
        gait_row_t got;
        bit        took_tick;
        bit        took_row;
        took_tick = (rst_n === 1'b1) && in_valid && !in_stall;
        took_row  = (rst_n === 1'b1) && out_valid && !out_stall;
        if (took_tick) board.note_tick(tick_count);
        if (took_row)
        begin
            got.row       = row_index;
            got.mask      = contact_mask;
            got.stance[0] = stance_phase_0;
            got.stance[1] = stance_phase_1;
            got.stance[2] = stance_phase_2;
            got.stance[3] = stance_phase_3;
            got.swing[0]  = swing_phase_0;
            got.swing[1]  = swing_phase_1;
            got.swing[2]  = swing_phase_2;
            got.swing[3]  = swing_phase_3;
            got.last      = last_row;
            board.check_row(got);
        end
        // watchdog: only handshakes count as progress
        if (took_tick || took_row || rst_n !== 1'b1)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request so the
    // two-entry queue fills and the block pushes back on tick words.
    initial
    begin : receiver
        int len;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                len = idle_len(stall_pct);
                out_stall <= (len > 0);
                if (len > 1) repeat (len - 1) @(posedge clk);
            end
        end
    end

    // Present one tick word, hold it until taken, then idle for gap cycles.
    task automatic offer_tick(logic [TICK_W-1:0] tick, int gap);
        in_valid   <= 1'b1;
        tick_count <= tick;
        valid_up   = 1'b1;
        do @(posedge clk); while (in_stall);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering, wait for every owed row, then let the block settle.
    // The first edge makes sure the last taken tick is already noted.
    task automatic drain(int settle);
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        @(posedge clk);
        while (board.outstanding() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        board.write_reg(idx, value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_setup(logic [CFG_W-1:0] nseg, logic [CFG_W-1:0] ipc,
                              logic [CFG_W-1:0] offs, logic [CFG_W-1:0] durs);
        set_reg(REG_NUM_SEGMENTS, nseg);
        set_reg(REG_ITERS, ipc);
        set_reg(REG_OFFSETS, offs);
        set_reg(REG_DURATIONS, durs);
    endtask

    // Random gait: offsets and durations mostly inside the cycle, some raw
    // bytes; count fields sometimes out of range or with junk above them.
    task automatic random_setup();
        int               n_raw;
        int               n_eff;
        int               ipc_raw;
        logic [CFG_W-1:0] nseg_word;
        logic [CFG_W-1:0] ipc_word;
        logic [CFG_W-1:0] offs;
        logic [CFG_W-1:0] durs;
        n_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        n_eff = (n_raw < 1) ? 1 : ((n_raw > SEG_CAP) ? SEG_CAP : n_raw);
        case ($urandom_range(0, 9))
            0:       ipc_raw = 0;
            1:       ipc_raw = $urandom_range(512, 1023);
            default: ipc_raw = $urandom_range(1, 12);
        endcase
        for (int leg = 0; leg < NUM_LEGS; leg++)
        begin
            offs[8*leg +: 8] = ($urandom_range(0, 5) == 0) ? 8'($urandom())
                                                          : 8'($urandom_range(0, n_eff - 1));
            durs[8*leg +: 8] = ($urandom_range(0, 5) == 0) ? 8'($urandom())
                                                          : 8'($urandom_range(0, n_eff));
        end
        nseg_word = ($urandom_range(0, 2) == 0) ? $urandom() : '0;
        nseg_word[NSEG_W-1:0] = NSEG_W'(n_raw);
        ipc_word = ($urandom_range(0, 2) == 0) ? $urandom() : '0;
        ipc_word[IPC_W-1:0] = IPC_W'(ipc_raw);
        load_setup(nseg_word, ipc_word, offs, durs);
    endtask

    initial
    begin : stimulus
        int               idx;
        logic [TICK_W-1:0] tick;
        board = new();
        rst_n      <= 1'b0;
        cfg_wr_en  <= 1'b0;
        cfg_index  <= REG_NUM_SEGMENTS;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        tick_count <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words: reset defaults first, then the corner setups
        gap_pct   = 20;
        stall_pct = 20;
        idx       = 0;
        for (int g = 0; g < DIR_GROUPS; g++)
        begin
            if (g > 0)
            begin
                drain(LATENCY);
                load_setup(DIR_NSEG[g], DIR_IPC[g], DIR_OFFS[g], DIR_DURS[g]);
            end
            while (idx < DIR_GROUP_END[g])
            begin
                offer_tick(DIR_TICKS[idx], idle_len(gap_pct));
                idx++;
            end
        end

        // random phases; phase 0 and 3 run back to back with no idling,
        // phase 3 also gets the long receiver hold-off
        tick = $urandom();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain(LATENCY);
            random_setup();
            gap_pct   = (ph == 0 || ph == 3) ? 0 : 35;
            stall_pct = (ph == 0 || ph == 3) ? 0 : 30;
            if (ph == 3) hold_request = 1'b1;
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                // sender pauses mid-phase until every owed row is out
                if (ph == 5 && k == PHASE_WORDS / 2) drain(0);
                tick = next_tick(tick);
                offer_tick(tick, idle_len(gap_pct));
            end
        end

        drain(LATENCY);
        board.close();
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
